// ----- src/nlpt_pkg.sv -----
package nlpt_pkg;

  localparam int ADDR_W = 16;
  localparam int AGE_W = 16;
  localparam int RETRY_W = 8;
  localparam int WAIT_W = 16;

  localparam logic [2:0] PH_HELLO = 3'd0;
  localparam logic [2:0] PH_AGE = 3'd1;
  localparam logic [2:0] PH_TEST = 3'd2;
  localparam logic [2:0] PH_POLL = 3'd3;
  localparam logic [2:0] PH_WAIT = 3'd4;

  localparam logic [2:0] ACT_HELLO = 3'd0;
  localparam logic [2:0] ACT_HELLO_ACK = 3'd1;
  localparam logic [2:0] ACT_DATA_ACK = 3'd2;
  localparam logic [2:0] ACT_POLL = 3'd3;
  localparam logic [2:0] ACT_EVICT = 3'd4;

  localparam logic [1:0] KIND_BAD = 2'd0;
  localparam logic [1:0] KIND_HELLO = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  localparam logic [2:0] REG_AGE_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_RETRY_LIMIT = 3'd1;
  localparam logic [2:0] REG_POLL_GAP = 3'd2;
  localparam logic [2:0] REG_TICKS_PER_SEC = 3'd3;
  localparam logic [2:0] REG_HELLO_PERIOD = 3'd4;
  localparam logic [2:0] REG_HELLO_REPEATS = 3'd5;

  typedef struct packed {
    logic        func;
    logic [15:0] node_addr;
    logic [1:0]  contact_kind;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] dest_addr;
    logic        table_full;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] age_timeout;
    logic [7:0]  retry_limit;
    logic [15:0] poll_gap_ticks;
    logic [7:0]  ticks_per_second;
    logic [23:0] hello_period_seconds;
    logic [7:0]  hello_repeats;
  } cfg_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] age;
    logic [7:0]  retries;
    logic [15:0] gap_left;
  } entry_t;

endpackage

// ----- src/nlpt_entry_ram.sv -----
module nlpt_entry_ram
  import nlpt_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

endmodule

// ----- src/node_liveness_poll_table.sv -----
// Liveness table for radio nodes. Node entries sit in a RAM with one read and
// one write port and a registered read; used bits sit in flip-flops. A
// bad-checksum or unknown contact and a hello tick are handled in the idle
// state, and a wait tick goes on through S_EMIT. A hello or data contact scans
// the RAM one entry a cycle until it finds the node or reaches the last entry
// and then writes back and acks in S_FIN; an age, test or poll tick sweeps
// every entry, and a poll sweep closes in S_END, so the entry sweep sets the
// rate. A new item is taken only when the output register is free. The poll
// tick may give up to TABLE_ENTRIES words; each poll word is held back until
// the next one or the end of the sweep so that the final one can carry last,
// and the sweep stalls while a held word waits for a free output register.
// The last word of each item carries last.
module node_liveness_poll_table
  import nlpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // contact lookup
  localparam logic [2:0] S_FIN = 3'd2;   // contact writeback and ack
  localparam logic [2:0] S_SWEEP = 3'd3; // age, test or poll sweep
  localparam logic [2:0] S_EMIT = 3'd4;  // wait-phase second check
  localparam logic [2:0] S_END = 3'd5;   // poll sweep close

  cfg_t cfg;
  logic [2:0] state;
  in_word_t item;
  logic [TABLE_ENTRIES-1:0] used;
  logic [2:0] phase;
  logic [7:0] tick_count;
  logic [23:0] second_count;
  logic [7:0] hellos_sent;

  // Sweep control. idx is the entry in the read register; rd_ok marks
  // that the RAM read data belongs to idx.
  logic [CNT_W-1:0] idx;
  logic rd_ok;
  logic found;
  logic free_ok;
  logic [IDX_W-1:0] found_idx;
  logic [IDX_W-1:0] free_idx;
  logic hit;
  logic emitted_any;
  out_word_t held;

  entry_t rd_data;
  logic wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t wr_data;
  logic [IDX_W-1:0] rd_idx;

  logic out_load;
  out_word_t out_word;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign cfg_ready = 1'b1;

  nlpt_entry_ram #(.DEPTH(TABLE_ENTRIES), .IDX_W(IDX_W)) u_ram (
    .clk(clk), .rd_idx(rd_idx), .rd_data(rd_data),
    .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
  );

  logic [IDX_W-1:0] cur;
  assign cur = idx[IDX_W-1:0];
  logic cur_used;
  assign cur_used = used[cur];
  logic timed_out;
  assign timed_out = cur_used && (rd_data.age >= cfg.age_timeout);
  logic at_end;
  assign at_end = (idx == LAST_IDX);

  // Poll decision for the entry in hand.
  logic do_evict, do_poll, need_out;
  always_comb begin
    do_evict = timed_out && (rd_data.retries >= cfg.retry_limit);
    do_poll = timed_out && !do_evict && (rd_data.gap_left == '0);
    need_out = do_evict || do_poll;
  end

  // End-of-second step, shared by wait and poll phases.
  logic sec_end;
  logic [23:0] sec_inc;
  logic [2:0] sec_phase;
  logic sec_reset;
  always_comb begin
    sec_end = (tick_count >= cfg.ticks_per_second);
    sec_inc = second_count + 24'd1;
    sec_reset = sec_inc >= cfg.hello_period_seconds;
    if (sec_reset || hellos_sent < cfg.hello_repeats) begin
      sec_phase = PH_HELLO;
    end else begin
      sec_phase = PH_AGE;
    end
  end

  // Read the next entry while the current one is being handled; during a
  // poll stall the read address holds. An idle block reads the first entry
  // so that a sweep or scan starts with it in hand.
  logic advance;
  always_comb begin
    advance = 1'b0;
    case (state)
      S_SCAN: advance = rd_ok;
      S_SWEEP: advance = rd_ok &&
                         (!(phase == PH_POLL && need_out && emitted_any) || out_free);
      default: advance = 1'b0;
    endcase
    if (state == S_IDLE) begin
      rd_idx = '0;
    end else if (advance && !at_end) begin
      rd_idx = cur + IDX_W'(1);
    end else begin
      rd_idx = cur;
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_idx = cur;
    wr_data = rd_data;
    if (state == S_SWEEP && advance && cur_used) begin
      if (phase == PH_AGE) begin
        wr_en = 1'b1;
        if (rd_data.age != '1) begin
          wr_data.age = rd_data.age + AGE_W'(1);
        end
      end else if (phase == PH_POLL && timed_out && !do_evict) begin
        wr_en = 1'b1;
        if (do_poll) begin
          wr_data.retries = rd_data.retries + RETRY_W'(1);
          wr_data.gap_left = cfg.poll_gap_ticks;
        end else begin
          wr_data.gap_left = rd_data.gap_left - WAIT_W'(1);
        end
      end
    end else if (state == S_FIN && (found || free_ok)) begin
      wr_en = 1'b1;
      wr_idx = found ? found_idx : free_idx;
      wr_data.addr = item.node_addr;
      wr_data.age = '0;
      wr_data.retries = '0;
      wr_data.gap_left = '0;
    end
  end

  // Words loaded into the output register; each load finds it free.
  always_comb begin
    out_load = 1'b0;
    out_word = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (!in_data.func) begin
            if (in_data.contact_kind == KIND_BAD) begin
              out_load = 1'b1;
              out_word = '{ACT_POLL, in_data.node_addr, 1'b0, 1'b1};
            end
          end else if (phase == PH_HELLO) begin
            out_load = 1'b1;
            out_word = '{ACT_HELLO, 16'd0, 1'b0, 1'b1};
          end
        end
      end
      S_FIN: begin
        out_load = 1'b1;
        out_word = '{(item.contact_kind == KIND_HELLO) ? ACT_HELLO_ACK : ACT_DATA_ACK,
                     item.node_addr, !(found || free_ok), 1'b1};
      end
      S_SWEEP: begin
        if (advance && phase == PH_POLL && need_out && emitted_any) begin
          out_load = 1'b1;
          out_word = held;
        end
      end
      S_END: begin
        if (emitted_any && out_free) begin
          out_load = 1'b1;
          out_word = '{held.action, held.dest_addr, 1'b0, 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_data <= out_word;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.age_timeout <= 16'd115;
      cfg.retry_limit <= 8'd5;
      cfg.poll_gap_ticks <= 16'd50;
      cfg.ticks_per_second <= 8'd10;
      cfg.hello_period_seconds <= 24'd200000;
      cfg.hello_repeats <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AGE_TIMEOUT: cfg.age_timeout <= cfg_data[15:0];
        REG_RETRY_LIMIT: cfg.retry_limit <= cfg_data[7:0];
        REG_POLL_GAP: cfg.poll_gap_ticks <= cfg_data[15:0];
        REG_TICKS_PER_SEC: cfg.ticks_per_second <= cfg_data[7:0];
        REG_HELLO_PERIOD: cfg.hello_period_seconds <= cfg_data;
        REG_HELLO_REPEATS: cfg.hello_repeats <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      phase <= PH_HELLO;
      tick_count <= '0;
      second_count <= '0;
      hellos_sent <= '0;
      idx <= '0;
      rd_ok <= 1'b0;
      found <= 1'b0;
      free_ok <= 1'b0;
      hit <= 1'b0;
      emitted_any <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          rd_ok <= 1'b0;
          found <= 1'b0;
          free_ok <= 1'b0;
          hit <= 1'b0;
          emitted_any <= 1'b0;
          if (in_valid && in_ready) begin
            item <= in_data;
            if (!in_data.func) begin
              if (in_data.contact_kind == KIND_HELLO ||
                  in_data.contact_kind == KIND_DATA) begin
                state <= S_SCAN;
                rd_ok <= 1'b1;
              end
            end else begin
              if (tick_count != 8'hFF) begin
                tick_count <= tick_count + 8'd1;
              end
              case (phase)
                PH_HELLO: begin
                  if (hellos_sent != 8'hFF) begin
                    hellos_sent <= hellos_sent + 8'd1;
                  end
                  phase <= PH_AGE;
                end
                PH_WAIT: state <= S_EMIT;
                PH_AGE, PH_TEST, PH_POLL: begin
                  state <= S_SWEEP;
                  rd_ok <= 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
        S_EMIT: begin
          // Wait-phase tick: the incremented tick count is now in place.
          state <= S_IDLE;
          if (sec_end) begin
            tick_count <= '0;
            second_count <= sec_reset ? '0 : sec_inc;
            if (sec_reset) begin
              hellos_sent <= '0;
            end
            phase <= sec_phase;
          end
        end
        S_SCAN: begin
          if (!cur_used) begin
            if (!free_ok) begin
              free_ok <= 1'b1;
              free_idx <= cur;
            end
          end else if (rd_data.addr == item.node_addr) begin
            found <= 1'b1;
            found_idx <= cur;
          end
          if (at_end || (cur_used && rd_data.addr == item.node_addr)) begin
            state <= S_FIN;
            rd_ok <= 1'b0;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_FIN: begin
          if (!found && free_ok) begin
            used[free_idx] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_SWEEP: begin
          if (advance) begin
            if (phase == PH_TEST && timed_out) begin
              hit <= 1'b1;
            end
            if (phase == PH_POLL && need_out) begin
              held <= '{do_evict ? ACT_EVICT : ACT_POLL, rd_data.addr, 1'b0, 1'b0};
              emitted_any <= 1'b1;
              if (do_evict) begin
                used[cur] <= 1'b0;
              end
            end
            if (at_end) begin
              rd_ok <= 1'b0;
              case (phase)
                PH_AGE: begin
                  phase <= PH_TEST;
                  state <= S_IDLE;
                end
                PH_TEST: begin
                  phase <= (hit || timed_out) ? PH_POLL : PH_WAIT;
                  state <= S_IDLE;
                end
                default: state <= S_END;
              endcase
            end else begin
              idx <= idx + CNT_W'(1);
            end
          end
        end
        S_END: begin
          // The held poll word leaves marked last once the output register
          // is free.
          if (!emitted_any || out_free) begin
            emitted_any <= 1'b0;
            state <= S_IDLE;
            if (sec_end) begin
              tick_count <= '0;
              second_count <= sec_reset ? '0 : sec_inc;
              if (sec_reset) begin
                hellos_sent <= '0;
              end
              phase <= sec_phase;
            end else begin
              phase <= PH_TEST;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The ack word always finds the output register free, as acceptance
  // required it and the scan emits nothing.
  a_fin_out_free: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> out_free)
    else $error("ack word would overwrite a pending word");

  a_idle_after_fin: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |=> state == S_IDLE)
    else $error("contact did not complete");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("item accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pending word dropped or changed");

endmodule
